FILE: hdl/dsc_pkg.sv
// Shared types, sizes and codes for the deadlock safety check block.
package dsc_pkg;

   localparam int NUM_PROCS   = 5;
   localparam int NUM_RES     = 3;
   localparam int COUNT_WIDTH = 8;
   localparam int WORK_WIDTH  = 16;

   localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int RES_W  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
   localparam int SUM_W  = COUNT_WIDTH + RES_W;

   localparam logic [1:0] MODE_LOAD_PROC  = 2'd0;
   localparam logic [1:0] MODE_LOAD_AVAIL = 2'd1;
   localparam logic [1:0] MODE_START      = 2'd2;

   localparam logic EVENT_DONE   = 1'b0;
   localparam logic EVENT_VICTIM = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] proc_index;
      logic [3:0] res_index;
      logic [7:0] alloc_value;
      logic [7:0] max_value;
      logic [7:0] avail_value;
   } req_type;

   typedef struct packed {
      logic [4:0] proc_id;
      logic       event_kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load_proc;
      logic load_avail;
      logic start;
      logic p_zero;
      logic p_next;
      logic r_clr;
      logic r_inc;
      logic found_clr;
      logic take_p;
      logic use_sel;
      logic release_r;
      logic acc_clr;
      logic acc_add;
      logic have_clr;
      logic victim_upd;
      logic take_victim;
      logic emit;
   } dsc_cmd_type;

   typedef struct packed {
      logic cur_done;
      logic fits_r;
      logic p_last;
      logic r_last;
      logic count_last;
      logic found;
      logic kind_victim;
   } dsc_status_type;

endpackage

FILE: hdl/dsc_datapath.sv
// Datapath: tables, work vector, done flags, scan counters and result register.
module dsc_datapath import dsc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   input  dsc_cmd_type    cmd,
   output dsc_status_type status,
   output rsp_type        rsp_data
);

   logic [COUNT_WIDTH-1:0] alloc_ff [NUM_PROCS][NUM_RES];
   logic [COUNT_WIDTH-1:0] max_ff   [NUM_PROCS][NUM_RES];
   logic [WORK_WIDTH-1:0]  work_ff  [NUM_RES];
   logic [NUM_PROCS-1:0]   done_ff, done_in;

   logic [PROC_W-1:0] p_ff, p_in;
   logic [RES_W-1:0]  r_ff, r_in;
   logic [PROC_W-1:0] count_ff, count_in;
   logic              found_ff, found_in;
   logic [PROC_W-1:0] sel_ff, sel_in;
   logic              kind_ff, kind_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  best_ff, best_in;
   logic [PROC_W-1:0] victim_ff, victim_in;
   logic              have_ff, have_in;
   rsp_type           rsp_ff, rsp_in;

   logic [PROC_W-1:0]      rd_p;
   logic [COUNT_WIDTH-1:0] alloc_rd, max_rd;
   logic [COUNT_WIDTH-1:0] need;
   logic [WORK_WIDTH:0]    work_sum;
   logic [WORK_WIDTH-1:0]  work_sat;
   logic [SUM_W-1:0]       total;
   logic                   better;
   logic                   proc_ok, res_ok;

   assign rd_p     = cmd.use_sel ? sel_ff : p_ff;
   assign alloc_rd = alloc_ff[rd_p][r_ff];
   assign max_rd   = max_ff[rd_p][r_ff];
   assign need     = (max_rd > alloc_rd) ? (max_rd - alloc_rd) : '0;
   assign work_sum = {1'b0, work_ff[r_ff]} + (WORK_WIDTH+1)'(alloc_rd);
   assign work_sat = work_sum[WORK_WIDTH] ? '1 : work_sum[WORK_WIDTH-1:0];
   assign total    = acc_ff + SUM_W'(alloc_rd);
   assign better   = !have_ff || (total > best_ff);
   assign proc_ok  = 32'(req_data.proc_index) < NUM_PROCS;
   assign res_ok   = 32'(req_data.res_index) < NUM_RES;

   assign status.cur_done    = done_ff[p_ff];
   assign status.fits_r      = WORK_WIDTH'(need) <= work_ff[r_ff];
   assign status.p_last      = p_ff == PROC_W'(NUM_PROCS - 1);
   assign status.r_last      = r_ff == RES_W'(NUM_RES - 1);
   assign status.count_last  = count_ff == PROC_W'(NUM_PROCS - 1);
   assign status.found       = found_ff;
   assign status.kind_victim = kind_ff == EVENT_VICTIM;

   assign rsp_data = rsp_ff;

   always_comb begin
      p_in      = p_ff;
      r_in      = r_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      done_in   = done_ff;
      sel_in    = sel_ff;
      kind_in   = kind_ff;
      acc_in    = acc_ff;
      best_in   = best_ff;
      victim_in = victim_ff;
      have_in   = have_ff;
      rsp_in    = rsp_ff;

      if (cmd.start) begin
         done_in  = '0;
         count_in = '0;
      end
      if (cmd.p_zero) begin
         p_in = '0;
      end else if (cmd.p_next) begin
         p_in = status.p_last ? '0 : p_ff + 1'b1;
      end
      if (cmd.r_clr || cmd.p_next || cmd.p_zero) begin
         r_in = '0;
      end else if (cmd.r_inc) begin
         r_in = r_ff + 1'b1;
      end
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = total;
      end
      if (cmd.have_clr) begin
         have_in = 1'b0;
      end else if (cmd.victim_upd && better) begin
         have_in   = 1'b1;
         best_in   = total;
         victim_in = p_ff;
      end
      if (cmd.take_p) begin
         sel_in  = p_ff;
         kind_in = EVENT_DONE;
      end else if (cmd.take_victim) begin
         sel_in  = victim_in;
         kind_in = EVENT_VICTIM;
      end
      if (cmd.emit) begin
         rsp_in.proc_id    = 5'(sel_ff);
         rsp_in.event_kind = kind_ff;
         rsp_in.last       = status.count_last;
         done_in[sel_ff]   = 1'b1;
         count_in          = count_ff + 1'b1;
      end
      // a new pass starts with nothing found yet
      if (cmd.found_clr) begin
         found_in = 1'b0;
      end else if (cmd.emit && kind_ff == EVENT_DONE) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff     <= '0;
         r_ff     <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
         done_ff  <= '0;
         have_ff  <= 1'b0;
         kind_ff  <= EVENT_DONE;
      end else begin
         p_ff     <= p_in;
         r_ff     <= r_in;
         count_ff <= count_in;
         found_ff <= found_in;
         done_ff  <= done_in;
         have_ff  <= have_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff    <= sel_in;
      acc_ff    <= acc_in;
      best_ff   <= best_in;
      victim_ff <= victim_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_proc && proc_ok && res_ok) begin
         alloc_ff[req_data.proc_index[PROC_W-1:0]][req_data.res_index[RES_W-1:0]] <=
            COUNT_WIDTH'(req_data.alloc_value);
         max_ff[req_data.proc_index[PROC_W-1:0]][req_data.res_index[RES_W-1:0]] <=
            COUNT_WIDTH'(req_data.max_value);
      end else if (cmd.release_r && kind_ff == EVENT_VICTIM) begin
         // drop the victim's holdings as they go back to work
         alloc_ff[rd_p][r_ff] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_avail && res_ok) begin
         work_ff[req_data.res_index[RES_W-1:0]] <= WORK_WIDTH'(req_data.avail_value[
            (COUNT_WIDTH < 8 ? COUNT_WIDTH : 8)-1:0]);
      end else if (cmd.release_r) begin
         work_ff[r_ff] <= work_sat;
      end
   end

endmodule

FILE: hdl/dsc_controller.sv
// Controller: sequences loads, safety passes, victim search and result hand-off.
module dsc_controller import dsc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_mode,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  dsc_status_type status,
   output dsc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      RELEASE,
      EMIT,
      VSEL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      out_free;

   assign req_stall  = state_ff != IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               priority if (req_mode == MODE_LOAD_PROC) begin
                  cmd.load_proc = 1'b1;
               end else if (req_mode == MODE_LOAD_AVAIL) begin
                  cmd.load_avail = 1'b1;
               end else if (req_mode == MODE_START) begin
                  cmd.start     = 1'b1;
                  cmd.p_zero    = 1'b1;
                  cmd.found_clr = 1'b1;
                  state_in      = SCAN;
               end else begin
                  cmd.load_proc = 1'b0;
               end
            end
         end

         SCAN: begin
            if (status.cur_done || !status.fits_r) begin
               cmd.p_next = 1'b1;
               if (status.p_last) begin
                  cmd.found_clr = 1'b1;
                  if (!status.found) begin
                     cmd.acc_clr  = 1'b1;
                     cmd.have_clr = 1'b1;
                     state_in     = VSEL;
                  end
               end
            end else if (status.r_last) begin
               cmd.take_p = 1'b1;
               cmd.r_clr  = 1'b1;
               state_in   = RELEASE;
            end else begin
               cmd.r_inc = 1'b1;
            end
         end

         RELEASE: begin
            cmd.use_sel   = 1'b1;
            cmd.release_r = 1'b1;
            if (status.r_last) begin
               cmd.r_clr = 1'b1;
               state_in  = EMIT;
            end else begin
               cmd.r_inc = 1'b1;
            end
         end

         EMIT: begin
            // hold until the result register can take the transaction
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               priority if (status.count_last) begin
                  state_in = IDLE;
               end else if (status.kind_victim) begin
                  cmd.p_zero    = 1'b1;
                  cmd.found_clr = 1'b1;
                  state_in      = SCAN;
               end else begin
                  cmd.p_next    = 1'b1;
                  cmd.found_clr = status.p_last;
                  state_in      = SCAN;
               end
            end
         end

         VSEL: begin
            if (status.cur_done || status.r_last) begin
               cmd.victim_upd = !status.cur_done;
               cmd.acc_clr    = 1'b1;
               cmd.p_next     = 1'b1;
               if (status.p_last) begin
                  cmd.take_victim = 1'b1;
                  state_in        = RELEASE;
               end
            end else begin
               cmd.acc_add = 1'b1;
               cmd.r_inc   = 1'b1;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/deadlock_safety_check_with_victim.sv
// Top level of the deadlock safety check with victim selection.
//
// Input channel (req_valid / req_stall / req_data): mode 0 loads one
// allocation and maximum entry, mode 1 loads one available count, mode 2
// starts a safety check, mode 3 is ignored. A load gives no transaction on the
// result channel. The input is stalled for the whole run of a check and is
// taken again once the last result is in the output register.
// Result channel (rsp_valid / rsp_stall / rsp_data): a check gives exactly
// NUM_PROCS transactions, each a completed process or a chosen victim, with
// last set on the final one. A result waits in the output register while
// rsp_stall is high; the sequencer holds in its emit step meanwhile.
// A check tests each process resource by resource in a pass, searches for a victim
// resource by resource per process, then updates the work vector one resource at a
// time and emits one result; the sequencer walks one resource entry per cycle.
// Reset clears the sequencer, the done flags and the output valid; tables
// and the work vector hold nothing meaningful until loaded.
module deadlock_safety_check_with_victim import dsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dsc_cmd_type    cmd;
   dsc_status_type status;

   dsc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dsc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
